// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the top-level RTL file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge, ignored while reset is active.
`define SBB_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error(msg);

// Check that an antecedent implies a consequent in the same cycle.
`define SBB_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== rtl/sbbeq_pkg.sv =====
// ----------------------------------------------------------------------------
// sbbeq_pkg
// Types and constants of the seven-band biquad equalizer.
// ----------------------------------------------------------------------------
package sbbeq_pkg;

    localparam int NUM_BANDS_DEF  = 7;
    localparam int FRAC_SHIFT_DEF = 15;

    localparam int COEF_W    = 18;
    localparam int SAMPLE_W  = 16;
    localparam int ACC_W     = 32;
    localparam int BAND_W    = 3;
    localparam int NUM_TERMS = 5;
    localparam int PH_W      = 3;

    localparam logic FUNC_LOAD   = 1'b0;
    localparam logic FUNC_SAMPLE = 1'b1;

    typedef logic signed [COEF_W-1:0]   t_coef;
    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic signed [ACC_W-1:0]    t_acc;

    // product order within one section
    typedef enum logic [PH_W-1:0] {
        TERM_B0,
        TERM_B1,
        TERM_B2,
        TERM_A1,
        TERM_A2
    } t_term;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } t_state;

    typedef struct packed {
        t_coef b0;
        t_coef b1;
        t_coef b2;
        t_coef a1;
        t_coef a2;
    } t_coef_set;

    typedef struct packed {
        logic mul_en;   // a product is issued this cycle
        logic first;    // product starts a new sum
        logic sub;      // product is subtracted
    } t_mac_ctl;

    typedef struct packed {
        logic    en;
        t_sample x;     // section input, becomes x1
        t_acc    y;     // section output, becomes y1
    } t_hist_wr;

endpackage

// ===== rtl/sbbeq_in_if.sv =====
// ----------------------------------------------------------------------------
// sbbeq_in_if
// Input channel: load or sample items, valid/ready handshake.
// ----------------------------------------------------------------------------
interface sbbeq_in_if;
    logic                       valid;
    logic                       ready;
    logic                       func;
    logic [sbbeq_pkg::BAND_W-1:0] band_index;
    sbbeq_pkg::t_coef           coef_b0;
    sbbeq_pkg::t_coef           coef_b1;
    sbbeq_pkg::t_coef           coef_b2;
    sbbeq_pkg::t_coef           coef_a1;
    sbbeq_pkg::t_coef           coef_a2;
    sbbeq_pkg::t_sample         sample_in;

    modport source (
        output valid, func, band_index, coef_b0, coef_b1, coef_b2,
               coef_a1, coef_a2, sample_in,
        input  ready
    );
    modport sink (
        input  valid, func, band_index, coef_b0, coef_b1, coef_b2,
               coef_a1, coef_a2, sample_in,
        output ready
    );
endinterface

// ===== rtl/sbbeq_out_if.sv =====
// ----------------------------------------------------------------------------
// sbbeq_out_if
// Output channel: one sample per item (zero for a load), valid/ready handshake.
// ----------------------------------------------------------------------------
interface sbbeq_out_if;
    logic               valid;
    logic               ready;
    sbbeq_pkg::t_sample sample_out;

    modport source (output valid, sample_out, input ready);
    modport sink   (input valid, sample_out, output ready);
endinterface

// ===== rtl/sbbeq_mac.sv =====
// ----------------------------------------------------------------------------
// sbbeq_mac
// Shared multiply-accumulate: registered 18x32 product, 32-bit wrapping sum.
// ----------------------------------------------------------------------------
module sbbeq_mac (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  sbbeq_pkg::t_mac_ctl i_ctl,
    input  sbbeq_pkg::t_coef    i_coef,
    input  sbbeq_pkg::t_acc     i_data,
    output sbbeq_pkg::t_acc     o_sum
);
    import sbbeq_pkg::*;

    logic signed [COEF_W+ACC_W-1:0] w_full;
    t_acc r_prod;
    t_acc r_acc;
    t_acc w_base;
    t_acc w_sum;
    logic r_pv;
    logic r_first;
    logic r_sub;

    // low 32 bits of the product match C's wrapping multiply
    assign w_full = i_coef * i_data;

    always_ff @(posedge i_clk) begin
        r_prod <= w_full[ACC_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv    <= 1'b0;
            r_first <= 1'b0;
            r_sub   <= 1'b0;
        end else begin
            r_pv    <= i_ctl.mul_en;
            r_first <= i_ctl.first;
            r_sub   <= i_ctl.sub;
        end
    end

    assign w_base = r_first ? '0 : r_acc;
    assign w_sum  = r_sub ? (w_base - r_prod) : (w_base + r_prod);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (r_pv) begin
            r_acc <= w_sum;
        end
    end

    assign o_sum = w_sum;

endmodule

// ===== rtl/sbbeq_bank.sv =====
// ----------------------------------------------------------------------------
// sbbeq_bank
// Per-band coefficient and history registers with operand select.
// ----------------------------------------------------------------------------
module sbbeq_bank #(
    parameter int NUM_BANDS = sbbeq_pkg::NUM_BANDS_DEF,
    parameter int BC_W      = (NUM_BANDS > 1) ? $clog2(NUM_BANDS) : 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_coef_wr,
    input  logic [BC_W-1:0]      i_coef_idx,
    input  sbbeq_pkg::t_coef_set i_coef,
    input  logic [BC_W-1:0]      i_band,
    input  sbbeq_pkg::t_term     i_term,
    input  sbbeq_pkg::t_sample   i_x,
    input  sbbeq_pkg::t_hist_wr  i_hist,
    output sbbeq_pkg::t_coef     o_coef,
    output sbbeq_pkg::t_acc      o_data
);
    import sbbeq_pkg::*;

    t_coef_set r_coef [NUM_BANDS];
    t_sample   r_xh1  [NUM_BANDS];
    t_sample   r_xh2  [NUM_BANDS];
    t_acc      r_yh1  [NUM_BANDS];
    t_acc      r_yh2  [NUM_BANDS];

    t_coef_set w_cs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_BANDS; k++) begin
                r_coef[k] <= '0;
            end
        end else if (i_coef_wr) begin
            r_coef[i_coef_idx] <= i_coef;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_BANDS; k++) begin
                r_xh1[k] <= '0;
                r_xh2[k] <= '0;
                r_yh1[k] <= '0;
                r_yh2[k] <= '0;
            end
        end else if (i_hist.en) begin
            r_xh2[i_band] <= r_xh1[i_band];
            r_xh1[i_band] <= i_hist.x;
            r_yh2[i_band] <= r_yh1[i_band];
            r_yh1[i_band] <= i_hist.y;
        end
    end

    assign w_cs = r_coef[i_band];

    always_comb begin
        unique case (i_term)
            TERM_B0: begin
                o_coef = w_cs.b0;
                o_data = {{(ACC_W-SAMPLE_W){i_x[SAMPLE_W-1]}}, i_x};
            end
            TERM_B1: begin
                o_coef = w_cs.b1;
                o_data = {{(ACC_W-SAMPLE_W){r_xh1[i_band][SAMPLE_W-1]}}, r_xh1[i_band]};
            end
            TERM_B2: begin
                o_coef = w_cs.b2;
                o_data = {{(ACC_W-SAMPLE_W){r_xh2[i_band][SAMPLE_W-1]}}, r_xh2[i_band]};
            end
            TERM_A1: begin
                o_coef = w_cs.a1;
                o_data = r_yh1[i_band];
            end
            TERM_A2: begin
                o_coef = w_cs.a2;
                o_data = r_yh2[i_band];
            end
            default: begin
                o_coef = '0;
                o_data = '0;
            end
        endcase
    end

endmodule

// ===== rtl/seven_band_biquad_equalizer.sv =====
// ----------------------------------------------------------------------------
// seven_band_biquad_equalizer
// Cascade of biquad IIR sections (Direct Form I) on one shared MAC.
// ----------------------------------------------------------------------------
// A load item (func = 0) writes b0, b1, b2, a1, a2 of one band and returns
// one item with sample_out = 0; a band index past the last band writes
// nothing. A sample item (func = 1) runs through every band in order, each
// band computing b0*x + b1*x1 + b2*x2 - a1*y1 - a2*y2 with 32-bit wrapping,
// then an arithmetic shift right by FRAC_SHIFT; the low 16 bits feed the next
// band and the last band's low 16 bits are the result. Nothing saturates.
// One 18x32 multiplier is shared by all products. Each band issues its five
// products one by one, then sums the last one and writes the history back in
// a closing phase. A sample item goes from acceptance through every band and
// the done state into the output register, and the next item can be accepted
// in the cycle after that; a load item goes through the done state alone. A
// result still waiting in the output register holds the finished item, and
// with it the input, until it is taken. The input is not ready while an item
// is in progress. The output register lets a new item be accepted while the
// previous result still waits to be taken.
// All coefficients and histories are cleared by reset.
`include "assert_macros.svh"

module seven_band_biquad_equalizer #(
    parameter int NUM_BANDS  = sbbeq_pkg::NUM_BANDS_DEF,
    parameter int FRAC_SHIFT = sbbeq_pkg::FRAC_SHIFT_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    sbbeq_in_if.sink      i_in,
    sbbeq_out_if.source   o_out
);
    import sbbeq_pkg::*;

    localparam int             BC_W       = (NUM_BANDS > 1) ? $clog2(NUM_BANDS) : 1;
    localparam logic [BC_W-1:0] LAST_BAND = BC_W'(NUM_BANDS - 1);
    localparam logic [PH_W-1:0] LAST_PHASE = PH_W'(NUM_TERMS);

    // sequencer state
    t_state          r_state, n_state;
    logic [PH_W-1:0] r_phase, n_phase;
    logic [BC_W-1:0] r_band,  n_band;
    t_sample         r_x,     n_x;       // current section input / result
    logic            r_out_valid, n_out_valid;
    t_sample         r_out_data,  n_out_data;

    // datapath links
    t_term     w_term;
    t_mac_ctl  w_mac_ctl;
    t_coef     w_coef;
    t_acc      w_data;
    t_acc      w_sum;
    t_acc      w_y;
    t_hist_wr  w_hist;
    t_coef_set w_coef_set;
    logic      w_coef_wr;
    logic      w_in_range;

    assign w_coef_set = '{b0: i_in.coef_b0, b1: i_in.coef_b1, b2: i_in.coef_b2,
                          a1: i_in.coef_a1, a2: i_in.coef_a2};
    assign w_in_range = (32'(i_in.band_index) < NUM_BANDS);

    // phases 0..4 issue one product each; the last phase only closes the sum
    assign w_term = (r_phase < LAST_PHASE) ? t_term'(r_phase) : TERM_B0;

    // arithmetic shift of the wrapped 32-bit sum
    assign w_y = w_sum >>> FRAC_SHIFT;

    sbbeq_bank #(
        .NUM_BANDS (NUM_BANDS),
        .BC_W      (BC_W)
    ) u_bank (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_coef_wr  (w_coef_wr),
        .i_coef_idx (BC_W'(i_in.band_index)),
        .i_coef     (w_coef_set),
        .i_band     (r_band),
        .i_term     (w_term),
        .i_x        (r_x),
        .i_hist     (w_hist),
        .o_coef     (w_coef),
        .o_data     (w_data)
    );

    sbbeq_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_mac_ctl),
        .i_coef  (w_coef),
        .i_data  (w_data),
        .o_sum   (w_sum)
    );

    assign i_in.ready       = (r_state == ST_IDLE);
    assign o_out.valid      = r_out_valid;
    assign o_out.sample_out = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_phase     <= '0;
            r_band      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_band      <= n_band;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_x        <= n_x;
        r_out_data <= n_out_data;
    end

    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_band      = r_band;
        n_x         = r_x;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        w_coef_wr   = 1'b0;
        w_mac_ctl   = '0;
        w_hist.en   = 1'b0;
        w_hist.x    = r_x;
        w_hist.y    = w_y;

        // result taken downstream
        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (i_in.valid) begin
                    n_phase = '0;
                    n_band  = '0;
                    if (i_in.func == FUNC_LOAD) begin
                        w_coef_wr = w_in_range;
                        n_x       = '0;
                        n_state   = ST_DONE;
                    end else begin
                        n_x     = i_in.sample_in;
                        n_state = ST_RUN;
                    end
                end
            end
            ST_RUN: begin
                w_mac_ctl.mul_en = (r_phase != LAST_PHASE);
                w_mac_ctl.first  = (r_phase == '0);
                w_mac_ctl.sub    = (w_term == TERM_A1) || (w_term == TERM_A2);
                if (r_phase == LAST_PHASE) begin
                    // close this band: update history, pass low half on
                    w_hist.en = 1'b1;
                    n_x       = w_y[SAMPLE_W-1:0];
                    n_phase   = '0;
                    if (r_band == LAST_BAND) begin
                        n_band  = '0;
                        n_state = ST_DONE;
                    end else begin
                        n_band = r_band + 1'b1;
                    end
                end else begin
                    n_phase = r_phase + 1'b1;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = r_x;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // a sample item always starts the band sequence
    `SBB_ASSERT(a_sample_starts_run, i_clk, i_rst_n,
        (i_in.valid && i_in.ready && i_in.func == FUNC_SAMPLE) |=> (r_state == ST_RUN),
        "sample item did not start the band sequence")

    // new results only come out of the done state
    `SBB_ASSERT(a_out_from_done, i_clk, i_rst_n,
        $rose(o_out.valid) |-> ($past(r_state) == ST_DONE),
        "output valid rose without a finished item")

    // phase counter is parked at zero outside the band sequence
    `SBB_ASSERT_IMPL(a_phase_parked, i_clk, i_rst_n,
        (r_state != ST_RUN), (r_phase == '0),
        "phase counter not cleared outside run")

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the seven-band biquad equalizer.
// ----------------------------------------------------------------------------
// Coefficient loads and audio samples are queued up front and sent by a
// clocked driver with random gaps. Each accepted item runs through a local
// model of the seven-section cascade, which yields the expected output item.
// A clocked monitor applies random back-pressure and checks every output item
// against the oldest expected sample.
// ----------------------------------------------------------------------------
module tb_top;
    import sbbeq_pkg::*;

    localparam int NB          = NUM_BANDS_DEF;
    localparam int ITEM_TARGET = 950;
    localparam int DRAIN_WAIT  = 60;         // a bit over one sample's latency
    localparam int CYCLE_LIMIT = 1_000_000;  // watchdog against a hung run
    localparam int MAX_REPORTS = 10;

    localparam t_coef   UNITY    = t_coef'(32768);     // 1.0 in Q15
    localparam t_coef   COEF_MAX = t_coef'(131071);
    localparam t_coef   COEF_MIN = t_coef'(-131072);
    localparam t_sample SMP_MAX  = t_sample'(32767);
    localparam t_sample SMP_MIN  = t_sample'(-32768);

    typedef struct {
        logic              func;
        logic [BAND_W-1:0] band;
        t_coef_set         coefs;
        t_sample           smp;
    } t_eq_item;

    logic i_clk;
    logic i_rst_n;

    sbbeq_in_if  in_if ();
    sbbeq_out_if out_if ();

    seven_band_biquad_equalizer dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // ------------------------------------------------------------------
    // Local copy of the equalizer state
    // ------------------------------------------------------------------
    t_coef_set band_coefs [NB];
    t_sample   x_hist1    [NB];
    t_sample   x_hist2    [NB];
    t_acc      y_hist1    [NB];
    t_acc      y_hist2    [NB];

    t_eq_item pending_items [$];
    t_sample  expected_samples [$];

    t_eq_item in_flight;
    int       in_gap;
    bit       in_steady;
    int       out_stall;
    bit       out_steady;
    int       mismatches;
    int       cycle_count;
    int       queued;
    t_sample  want;

    // Applies one item to the local state and returns the expected output.
    // All products and sums stay at 32 bits, so they wrap like the hardware.
    function automatic t_sample equalize(input t_eq_item it);
        t_acc    acc;
        t_sample x;
        int      k;
        if (it.func == FUNC_LOAD) begin
            // a band past the last one is dropped, but still answers 0
            if (it.band < NB)
                band_coefs[it.band] = it.coefs;
            return '0;
        end
        x = it.smp;
        for (k = 0; k < NB; k++) begin
            acc = t_acc'(band_coefs[k].b0) * t_acc'(x)
                + t_acc'(band_coefs[k].b1) * t_acc'(x_hist1[k])
                + t_acc'(band_coefs[k].b2) * t_acc'(x_hist2[k])
                - t_acc'(band_coefs[k].a1) * y_hist1[k]
                - t_acc'(band_coefs[k].a2) * y_hist2[k];
            acc = acc >>> FRAC_SHIFT_DEF;
            x_hist2[k] = x_hist1[k];
            x_hist1[k] = x;
            y_hist2[k] = y_hist1[k];
            y_hist1[k] = acc;          // full 32 bits kept as feedback
            x          = acc[SAMPLE_W-1:0];
        end
        return x;
    endfunction

    // ------------------------------------------------------------------
    // Random value helpers
    // ------------------------------------------------------------------
    // mostly short, a few long
    function automatic int pause_len();
        if ($urandom_range(9) == 0)
            return $urandom_range(20, 90);
        return $urandom_range(1, 4);
    endfunction

    function automatic t_coef wild_coef();
        int pick;
        pick = $urandom_range(9);
        if (pick < 5)
            return t_coef'($urandom);
        if (pick < 8)
            return t_coef'(int'($urandom_range(16383)) - 8192);
        case ($urandom_range(4))
            0:       return COEF_MAX;
            1:       return COEF_MIN;
            2:       return UNITY;
            3:       return -UNITY;
            default: return '0;
        endcase
    endfunction

    // near-unity band with mild feedback, keeps the cascade bounded
    function automatic t_coef_set gentle_coefs();
        t_coef_set c;
        c.b0 = t_coef'(int'($urandom_range(24576, 40960)));
        c.b1 = t_coef'(int'($urandom_range(8191)) - 4096);
        c.b2 = t_coef'(int'($urandom_range(8191)) - 4096);
        c.a1 = t_coef'(int'($urandom_range(16383)) - 8192);
        c.a2 = t_coef'(int'($urandom_range(8191)) - 4096);
        return c;
    endfunction

    function automatic t_coef_set wild_coefs();
        t_coef_set c;
        c.b0 = wild_coef();
        c.b1 = wild_coef();
        c.b2 = wild_coef();
        c.a1 = wild_coef();
        c.a2 = wild_coef();
        return c;
    endfunction

    function automatic t_sample rand_sample();
        int pick;
        pick = $urandom_range(9);
        if (pick < 6)
            return t_sample'($urandom);
        if (pick < 8)
            return t_sample'(int'($urandom_range(511)) - 256);
        case ($urandom_range(3))
            0:       return SMP_MAX;
            1:       return SMP_MIN;
            2:       return t_sample'(-1);
            default: return '0;
        endcase
    endfunction

    // Unused fields still carry random bits so every input bit toggles.
    task automatic queue_load(input logic [BAND_W-1:0] band, input t_coef_set c);
        t_eq_item it;
        it.func  = FUNC_LOAD;
        it.band  = band;
        it.coefs = c;
        it.smp   = t_sample'($urandom);
        pending_items.push_back(it);
        queued++;
    endtask

    task automatic queue_sample(input t_sample s);
        t_eq_item it;
        it.func  = FUNC_SAMPLE;
        it.band  = BAND_W'($urandom);
        it.coefs = t_coef_set'({$urandom, $urandom, $urandom});
        it.smp   = s;
        pending_items.push_back(it);
        queued++;
    endtask

    // ------------------------------------------------------------------
    // Clock, reset, watchdog
    // ------------------------------------------------------------------
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    initial begin
        i_rst_n = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    always @(posedge i_clk)
        cycle_count <= cycle_count + 1;

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("end of test: mismatches");
        $finish;
    end

    // ------------------------------------------------------------------
    // Input driver
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else begin
            // model runs in acceptance order, which is the block's order
            if (in_if.valid && in_if.ready) begin
                expected_samples.push_back(equalize(in_flight));
                if ($urandom_range(63) == 0)
                    in_steady = !in_steady;
            end
            if (!in_if.valid || in_if.ready) begin
                if (in_gap > 0) begin
                    in_gap--;
                    in_if.valid <= 1'b0;
                end else if (pending_items.size() > 0) begin
                    in_flight = pending_items.pop_front();
                    in_if.valid      <= 1'b1;
                    in_if.func       <= in_flight.func;
                    in_if.band_index <= in_flight.band;
                    in_if.coef_b0    <= in_flight.coefs.b0;
                    in_if.coef_b1    <= in_flight.coefs.b1;
                    in_if.coef_b2    <= in_flight.coefs.b2;
                    in_if.coef_a1    <= in_flight.coefs.a1;
                    in_if.coef_a2    <= in_flight.coefs.a2;
                    in_if.sample_in  <= in_flight.smp;
                    in_gap = (in_steady || $urandom_range(1) == 0) ? 0 : pause_len();
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Output monitor and back-pressure
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                if (expected_samples.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("unexpected output item: sample_out=%0d",
                                 out_if.sample_out);
                end else begin
                    want = expected_samples.pop_front();
                    if (out_if.sample_out !== want) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                            $display("sample_out mismatch: expected %0d, got %0d",
                                     want, out_if.sample_out);
                    end
                end
                if ($urandom_range(63) == 0)
                    out_steady = !out_steady;
            end
            if (out_stall > 0) begin
                out_stall--;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= 1'b1;
                if (!out_steady && $urandom_range(5) == 0)
                    out_stall = pause_len();
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    initial begin
        t_coef_set c;
        int        b;
        int        n;
        int        pick;
        int        i;

        in_if.valid      = 1'b0;
        in_if.func       = FUNC_LOAD;
        in_if.band_index = '0;
        in_if.coef_b0    = '0;
        in_if.coef_b1    = '0;
        in_if.coef_b2    = '0;
        in_if.coef_a1    = '0;
        in_if.coef_a2    = '0;
        in_if.sample_in  = '0;
        out_if.ready     = 1'b0;
        in_gap      = 0;
        in_steady   = 1'b0;
        out_stall   = 0;
        out_steady  = 1'b0;
        mismatches  = 0;
        cycle_count = 0;
        queued      = 0;
        for (b = 0; b < NB; b++) begin
            band_coefs[b] = '0;
            x_hist1[b]    = '0;
            x_hist2[b]    = '0;
            y_hist1[b]    = '0;
            y_hist2[b]    = '0;
        end

        // cleared coefficients: everything filters to zero
        queue_sample(SMP_MAX);
        queue_sample(SMP_MIN);

        // unity pass-through in every band
        c = '{b0: UNITY, default: '0};
        for (b = 0; b < NB; b++)
            queue_load(BAND_W'(b), c);
        queue_sample(SMP_MIN);
        queue_sample(SMP_MAX);
        queue_sample(t_sample'(1));
        queue_sample(t_sample'(-1));

        // out-of-range band must leave pass-through intact
        queue_load(BAND_W'(NB), '{default: COEF_MAX});
        queue_sample(t_sample'(12345));

        // extreme coefficients, wrapping through feedback
        queue_load(BAND_W'(3), '{default: COEF_MIN});
        queue_sample(SMP_MAX);
        queue_sample(SMP_MIN);
        queue_load(BAND_W'(5), '{default: COEF_MAX});
        queue_sample(SMP_MAX);
        queue_sample(SMP_MIN);
        queue_sample(t_sample'(0));

        // random part: mostly full filter programs followed by sample runs
        while (queued < ITEM_TARGET) begin
            pick = $urandom_range(9);
            if (pick < 7) begin
                n = $urandom_range(1);
                for (b = 0; b < NB; b++)
                    queue_load(BAND_W'(b), n ? gentle_coefs() : wild_coefs());
                n = $urandom_range(8, 40);
                for (i = 0; i < n; i++)
                    queue_sample(rand_sample());
            end else if (pick < 9) begin
                // retune one band mid-stream, band 7 now and then
                queue_load(BAND_W'($urandom_range(NB)), wild_coefs());
                n = $urandom_range(1, 10);
                for (i = 0; i < n; i++)
                    queue_sample(rand_sample());
            end else begin
                n = $urandom_range(1, 6);
                for (i = 0; i < n; i++) begin
                    if ($urandom_range(1) == 0)
                        queue_load(BAND_W'($urandom), wild_coefs());
                    else
                        queue_sample(t_sample'($urandom));
                end
            end
        end

        // sample on the falling edge so the check never races the driver
        while (pending_items.size() != 0 || in_if.valid || expected_samples.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_WAIT) @(negedge i_clk);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
